// ===== sv/vcs_pkg.sv =====
// shared types and constants for the visual centering servo
package vcs_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int OpW      = 18;
    localparam int ProdW    = 2 * OpW;
    localparam int FiltW    = 18;
    localparam int CmdW     = 16;

    localparam logic [CfgIdxW-1:0] REG_GAIN_SURGE   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_GAIN_SWAY    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SURGE_LIMIT  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SWAY_LIMIT   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SEARCH_SURGE = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_LOCK_RADIUS  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_TIMEOUT_MS   = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_FILTER_ALPHA = 3'd7;

    localparam logic [15:0] AIM_COL       = 16'd5120;
    localparam logic [15:0] AIM_ROW       = 16'd3840;
    localparam logic [7:0]  STABLE_FRAMES = 8'd10;
    localparam logic [16:0] ALPHA_ONE     = 17'h10000;

    typedef struct packed {
        logic [15:0]        gain_surge;
        logic [15:0]        gain_sway;
        logic [14:0]        surge_limit;
        logic [14:0]        sway_limit;
        logic signed [15:0] search_surge;
        logic [16:0]        lock_radius;
        logic [31:0]        timeout_ms;
        logic [16:0]        filter_alpha;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_RUN      = 2'd0,
        ST_CENTRED  = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_HALTED   = 2'd3
    } status_t;

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_HALT  = 1'b1
    } cmd_t;

endpackage

// ===== sv/vcs_cfg.sv =====
// configuration register file of the visual centering servo
module vcs_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vcs_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [vcs_pkg::CfgDataW-1:0]  cfg_data,
    output vcs_pkg::cfg_t                 cfg
);
    import vcs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_surge   <= 16'd256;
            cfg_reg.gain_sway    <= 16'd256;
            cfg_reg.surge_limit  <= 15'd16384;
            cfg_reg.sway_limit   <= 15'd16384;
            cfg_reg.search_surge <= 16'sd4096;
            cfg_reg.lock_radius  <= 17'd320;
            cfg_reg.timeout_ms   <= 32'd30000;
            cfg_reg.filter_alpha <= 17'd19661;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_SURGE:   cfg_reg.gain_surge   <= cfg_data[15:0];
                REG_GAIN_SWAY:    cfg_reg.gain_sway    <= cfg_data[15:0];
                REG_SURGE_LIMIT:  cfg_reg.surge_limit  <= cfg_data[14:0];
                REG_SWAY_LIMIT:   cfg_reg.sway_limit   <= cfg_data[14:0];
                REG_SEARCH_SURGE: cfg_reg.search_surge <= $signed(cfg_data[15:0]);
                REG_LOCK_RADIUS:  cfg_reg.lock_radius  <= cfg_data[16:0];
                REG_TIMEOUT_MS:   cfg_reg.timeout_ms   <= cfg_data[31:0];
                REG_FILTER_ALPHA: cfg_reg.filter_alpha <= cfg_data[16:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/vcs_mul.sv =====
// shared signed multiplier with registered product
module vcs_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [vcs_pkg::OpW-1:0]      op_a,
    input  logic signed [vcs_pkg::OpW-1:0]      op_b,
    output logic signed [vcs_pkg::ProdW-1:0]    prod
);
    import vcs_pkg::*;

    logic signed [ProdW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== sv/visual_centering_servo.sv =====
// top level of the visual centering servo: sequencer, filters and command shaping
//
//  channel | signals                                          | beat taken when
//  --------+--------------------------------------------------+-----------------------
//  in      | in_valid in_ready cmd time_ms target_seen        | in_valid & in_ready
//          | target_x target_y                                |
//  out     | out_valid out_ready status surge_cmd sway_cmd    | out_valid & out_ready
//          | searching                                        |
//  cfg     | cfg_we cfg_index cfg_data                        | cfg_we
//
//  halt, timeout and search beats go from S_EVAL straight to S_DONE
//  tracked frames run S_FX to S_SU: one multiplier is used four times in turn
//  (x filter, y filter, sway gain, surge gain), each product registered
//  a centred frame goes from S_CHK to S_DONE and uses neither gain product
//  a new beat is taken while the previous result still waits in the output register
//  reset is asynchronous, active low, and restores control, tracking and cfg registers
module visual_centering_servo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [31:0]                   time_ms,
    input  logic                          target_seen,
    input  logic [15:0]                   target_x,
    input  logic [15:0]                   target_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic signed [15:0]            surge_cmd,
    output logic signed [15:0]            sway_cmd,
    output logic                          searching,
    input  logic                          cfg_we,
    input  logic [vcs_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [vcs_pkg::CfgDataW-1:0]  cfg_data
);
    import vcs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EVAL = 9'b000000010,
        S_FX   = 9'b000000100,
        S_FY   = 9'b000001000,
        S_FYU  = 9'b000010000,
        S_CHK  = 9'b000100000,
        S_SW   = 9'b001000000,
        S_SU   = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    function automatic logic signed [CmdW-1:0] sat_cmd(
        input logic signed [28:0] v,
        input logic [14:0]        m
    );
        logic signed [28:0] hi;
        logic signed [28:0] lo;
        hi = $signed({14'd0, m});
        lo = -hi;
        if (v > hi)
            sat_cmd = hi[CmdW-1:0];
        else if (v < lo)
            sat_cmd = lo[CmdW-1:0];
        else
            sat_cmd = v[CmdW-1:0];
    endfunction

    cfg_t cfg;

    state_t state_reg, state_next;

    logic                   cmd_reg;
    logic [31:0]            time_reg;
    logic                   seen_reg;
    logic [15:0]            tx_reg;
    logic [15:0]            ty_reg;

    logic                   active_reg;
    logic                   acquired_reg;
    logic [31:0]            start_reg;
    logic [7:0]             count_reg;
    logic signed [FiltW-1:0] fx_reg;
    logic signed [FiltW-1:0] fy_reg;

    status_t                res_status_reg;
    logic signed [CmdW-1:0] res_surge_reg;
    logic signed [CmdW-1:0] res_sway_reg;
    logic                   res_search_reg;

    logic                   out_valid_reg;
    status_t                status_reg;
    logic signed [CmdW-1:0] surge_reg;
    logic signed [CmdW-1:0] sway_reg;
    logic                   search_reg;

    logic [31:0]            elapsed;
    logic                   timed_out;
    logic                   halt;
    logic signed [FiltW-1:0] raw_x, raw_y, diff_x, diff_y;
    logic [16:0]            alpha_eff;
    logic signed [OpW-1:0]  op_a, op_b;
    logic                   mul_en;
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW:0]  neg_prod;
    logic [FiltW-1:0]       fx_abs, fy_abs;
    logic                   centred;
    logic [7:0]             count_inc;
    logic                   success;
    logic signed [CmdW-1:0] surge_lim_s;
    logic signed [CmdW-1:0] reacq_clamped;
    logic                   can_load;

    vcs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vcs_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign halt      = (cmd_reg == CMD_HALT);
    assign elapsed   = time_reg - (active_reg ? start_reg : time_reg);
    assign timed_out = (elapsed >= cfg.timeout_ms);

    assign raw_x  = $signed({2'b00, tx_reg}) - $signed({2'b00, AIM_COL});
    assign raw_y  = $signed({2'b00, ty_reg}) - $signed({2'b00, AIM_ROW});
    assign diff_x = raw_x - fx_reg;
    assign diff_y = raw_y - fy_reg;

    assign alpha_eff = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;

    always_comb
    begin
        op_a   = $signed({1'b0, alpha_eff});
        op_b   = diff_x;
        mul_en = 1'b0;
        case (state_reg)
            S_FX:
            begin
                mul_en = 1'b1;
            end
            S_FY:
            begin
                op_b   = diff_y;
                mul_en = 1'b1;
            end
            S_CHK:
            begin
                op_a   = $signed({2'b00, cfg.gain_sway});
                op_b   = fx_reg;
                mul_en = 1'b1;
            end
            S_SW:
            begin
                op_a   = $signed({2'b00, cfg.gain_surge});
                op_b   = fy_reg;
                mul_en = 1'b1;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign neg_prod = -$signed({prod[ProdW-1], prod});

    assign fx_abs  = fx_reg[FiltW-1] ? (~fx_reg + 18'd1) : fx_reg;
    assign fy_abs  = fy_reg[FiltW-1] ? (~fy_reg + 18'd1) : fy_reg;
    assign centred = (fx_abs < {1'b0, cfg.lock_radius})
                  && (fy_abs < {1'b0, cfg.lock_radius});
    assign count_inc = (count_reg == 8'hFF) ? count_reg : count_reg + 8'd1;
    assign success   = centred && (count_inc >= STABLE_FRAMES);

    assign surge_lim_s   = $signed({1'b0, cfg.surge_limit});
    assign reacq_clamped = cfg.search_surge[CmdW-1] ? 16'sd0
                         : ((cfg.search_surge > surge_lim_s) ? surge_lim_s
                                                             : cfg.search_surge);

    assign can_load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (halt || timed_out || !seen_reg)
                    state_next = S_DONE;
                else
                    state_next = S_FX;
            end
            S_FX:  state_next = S_FY;
            S_FY:  state_next = S_FYU;
            S_FYU: state_next = S_CHK;
            S_CHK:
            begin
                if (success)
                    state_next = S_DONE;
                else
                    state_next = S_SW;
            end
            S_SW:  state_next = S_SU;
            S_SU:  state_next = S_DONE;
            S_DONE:
            begin
                if (can_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            acquired_reg  <= 1'b0;
            start_reg     <= 32'd0;
            count_reg     <= 8'd0;
            fx_reg        <= '0;
            fy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_EVAL:
                begin
                    if (halt)
                    begin
                        active_reg   <= 1'b0;
                        acquired_reg <= 1'b0;
                        count_reg    <= 8'd0;
                        fx_reg       <= '0;
                        fy_reg       <= '0;
                    end
                    else
                    begin
                        if (!active_reg)
                            start_reg <= time_reg;
                        // fresh start, lost target or newly seen target
                        if (!active_reg || (!timed_out && !(seen_reg && acquired_reg)))
                        begin
                            count_reg <= 8'd0;
                            fx_reg    <= '0;
                            fy_reg    <= '0;
                        end
                        if (timed_out)
                        begin
                            active_reg   <= 1'b0;
                            acquired_reg <= 1'b0;
                        end
                        else
                        begin
                            active_reg   <= 1'b1;
                            acquired_reg <= seen_reg;
                        end
                    end
                end
                S_FY:
                begin
                    fx_reg <= fx_reg + prod[16+FiltW-1:16];
                end
                S_FYU:
                begin
                    fy_reg <= fy_reg + prod[16+FiltW-1:16];
                end
                S_CHK:
                begin
                    if (centred)
                        count_reg <= count_inc;
                    else
                        count_reg <= 8'd0;
                    if (success)
                    begin
                        active_reg   <= 1'b0;
                        acquired_reg <= 1'b0;
                    end
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase

            if ((state_reg == S_DONE) && can_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // beat payload, staged results and output register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= cmd;
            time_reg <= time_ms;
            seen_reg <= target_seen;
            tx_reg   <= target_x;
            ty_reg   <= target_y;
        end

        case (state_reg)
            S_EVAL:
            begin
                res_sway_reg <= 16'sd0;
                if (halt)
                begin
                    res_status_reg <= ST_HALTED;
                    res_surge_reg  <= 16'sd0;
                    res_search_reg <= 1'b0;
                end
                else if (timed_out)
                begin
                    res_status_reg <= ST_TIMEOUT;
                    res_surge_reg  <= 16'sd0;
                    res_search_reg <= 1'b0;
                end
                else
                begin
                    res_status_reg <= ST_RUN;
                    res_surge_reg  <= seen_reg ? 16'sd0 : reacq_clamped;
                    res_search_reg <= !seen_reg;
                end
            end
            S_CHK:
            begin
                if (success)
                    res_status_reg <= ST_CENTRED;
            end
            S_SW:
            begin
                res_sway_reg <= sat_cmd($signed({prod[ProdW-1], prod[ProdW-1:8]}),
                                        cfg.sway_limit);
            end
            S_SU:
            begin
                res_surge_reg <= sat_cmd(neg_prod[ProdW:8], cfg.surge_limit);
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    status_reg <= res_status_reg;
                    surge_reg  <= res_surge_reg;
                    sway_reg   <= res_sway_reg;
                    search_reg <= res_search_reg;
                end
            end
            default:
            begin
                res_search_reg <= res_search_reg;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign surge_cmd = surge_reg;
    assign sway_cmd  = sway_reg;
    assign searching = search_reg;

`ifndef SYNTH
    a_accept_starts_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_EVAL)
        else $error("accepted beat did not start evaluation");

    a_stop_zero_cmds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_CENTRED || status == ST_TIMEOUT || status == ST_HALTED)
        |-> surge_cmd == 16'sd0 && sway_cmd == 16'sd0)
        else $error("nonzero command with a stop status");

    a_search_cmds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && searching |-> sway_cmd == 16'sd0 && !surge_cmd[15]
        && status == ST_RUN)
        else $error("bad commands while searching");

    a_sway_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sway_cmd <= $signed({1'b0, cfg.sway_limit})
        && sway_cmd >= -$signed({1'b0, cfg.sway_limit}))
        else $error("sway command beyond saturation");
`endif

endmodule
